FILE: rtl/core/mnht_pkg.sv
// Shared types, command codes and defaults for the MIDI note history tracker.
package mnht_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam logic [1:0] CMD_NOTE  = 2'd0;
   localparam logic [1:0] CMD_TICK  = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;
   localparam logic [1:0] CMD_CLEAR = 2'd3;

   localparam logic [31:0] RELEASED_NONE = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      OP_NOTE_ON,
      OP_NOTE_OFF,
      OP_TICK,
      OP_READ,
      OP_CLEAR
   } op_type;

   typedef enum logic [0:0] {
      BK_IDLE,
      BK_READ
   } back_state_type;

   typedef struct packed {
      logic [1:0] command;
      logic [6:0] note_number;
      logic [6:0] note_velocity;
      logic       is_onset;
   } req_type;

   typedef struct packed {
      logic               entry_present;
      logic [6:0]         entry_note;
      logic [6:0]         entry_velocity;
      logic               still_pressed;
      logic [31:0]        ms_since_pressed;
      logic signed [31:0] ms_since_released;
      logic [31:0]        held_ms;
      logic               last_entry;
   } rsp_type;

   typedef struct packed {
      op_type     op;
      logic [6:0] note;
      logic [6:0] velocity;
   } op_item_type;

   typedef struct packed {
      logic [6:0]  note;
      logic [6:0]  velocity;
      logic [31:0] press_stamp;
      logic [31:0] release_stamp;
   } slot_type;

endpackage

FILE: rtl/core/mnht_front.sv
// Front end: accepts requests, classifies them and queues them for the history unit.
module mnht_front import mnht_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  req_type     req_data,
   output logic        q_valid,
   output op_item_type q_item,
   input  logic        q_pop
);

   op_item_type queue_ff [2];
   logic        wr_ptr_ff;
   logic        wr_ptr_in;
   logic        rd_ptr_ff;
   logic        rd_ptr_in;
   logic [1:0]  count_ff;
   logic [1:0]  count_in;
   op_item_type item_in;
   logic        push;
   logic        pop;

   always_comb begin
      item_in.note     = req_data.note_number;
      item_in.velocity = req_data.note_velocity;
      unique case (req_data.command)
         CMD_NOTE:  item_in.op = req_data.is_onset ? OP_NOTE_ON : OP_NOTE_OFF;
         CMD_TICK:  item_in.op = OP_TICK;
         CMD_READ:  item_in.op = OP_READ;
         CMD_CLEAR: item_in.op = OP_CLEAR;
      endcase
   end

   assign req_full = (count_ff == 2'd2);
   assign q_valid  = (count_ff != 2'd0);
   assign q_item   = queue_ff[rd_ptr_ff];
   assign push     = req_push && !req_full;
   assign pop      = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

FILE: rtl/core/mnht_back.sv
// Back end: history shift cells, read sequencer and result register.
module mnht_back import mnht_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  op_item_type q_item,
   output logic        q_pop,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output rsp_type     rsp_data
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);
   localparam logic [IW-1:0] LAST_IDX  = IW'(DEPTH - 1);

   back_state_type state_ff;
   back_state_type state_in;
   logic [CW-1:0]  count_ff;
   logic [CW-1:0]  count_in;
   logic [31:0]    clock_ff;
   logic [31:0]    clock_in;
   logic [IW-1:0]  idx_ff;
   logic [IW-1:0]  idx_in;
   logic [DEPTH-1:0] pressed_ff;
   logic [DEPTH-1:0] pressed_in;
   slot_type       slot_ff [DEPTH];
   slot_type       slot_in [DEPTH];
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   rsp_type        rsp_data_ff;
   rsp_type        rsp_data_in;

   logic           out_free;
   logic           do_note;
   logic           do_onset;
   logic           do_rotate;
   logic           do_clear;
   logic           load_rsp;
   logic           emit;
   logic [DEPTH-1:0] pressed_rel;
   slot_type       slot_rel [DEPTH];
   rsp_type        entry_rsp;
   rsp_type        marker_rsp;
   logic [31:0]    since_press;
   logic [31:0]    since_rel;
   logic [31:0]    rel_held;

   assign out_free  = !rsp_valid_ff || rsp_pop;
   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign emit      = (CW'(idx_ff) < count_ff);

   // Result for the slot at the head of the history.
   always_comb begin
      since_press = clock_ff - slot_ff[0].press_stamp;
      since_rel   = clock_ff - slot_ff[0].release_stamp;
      rel_held    = slot_ff[0].release_stamp - slot_ff[0].press_stamp;
      entry_rsp.entry_present     = 1'b1;
      entry_rsp.entry_note        = slot_ff[0].note;
      entry_rsp.entry_velocity    = slot_ff[0].velocity;
      entry_rsp.still_pressed     = pressed_ff[0];
      entry_rsp.ms_since_pressed  = since_press;
      entry_rsp.ms_since_released = pressed_ff[0] ? RELEASED_NONE : since_rel;
      entry_rsp.held_ms           = pressed_ff[0] ? since_press : rel_held;
      entry_rsp.last_entry        = (CW'(idx_ff) == CW'(count_ff - 1'b1));
      marker_rsp                  = '0;
      marker_rsp.last_entry       = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      clock_in    = clock_ff;
      q_pop       = 1'b0;
      do_note     = 1'b0;
      do_onset    = 1'b0;
      do_rotate   = 1'b0;
      do_clear    = 1'b0;
      load_rsp    = 1'b0;
      rsp_data_in = rsp_data_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               unique case (q_item.op)
                  OP_NOTE_ON: begin
                     q_pop    = 1'b1;
                     do_note  = 1'b1;
                     do_onset = 1'b1;
                  end
                  OP_NOTE_OFF: begin
                     q_pop   = 1'b1;
                     do_note = 1'b1;
                  end
                  OP_TICK: begin
                     q_pop    = 1'b1;
                     clock_in = clock_ff + 32'd1;
                  end
                  OP_CLEAR: begin
                     q_pop    = 1'b1;
                     do_clear = 1'b1;
                     clock_in = '0;
                  end
                  OP_READ: begin
                     if (out_free) begin
                        q_pop = 1'b1;
                        if (count_ff == '0) begin
                           load_rsp    = 1'b1;
                           rsp_data_in = marker_rsp;
                        end else begin
                           state_in = BK_READ;
                           idx_in   = '0;
                        end
                     end
                  end
                  default: q_pop = 1'b1;
               endcase
            end
         end
         BK_READ: begin
            // Rotate the whole history once around; emit only the live slots.
            if (!emit || out_free) begin
               do_rotate = 1'b1;
               if (emit) begin
                  load_rsp    = 1'b1;
                  rsp_data_in = entry_rsp;
               end
               if (idx_ff == LAST_IDX) begin
                  state_in = BK_IDLE;
                  idx_in   = '0;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: state_in = BK_IDLE;
      endcase
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Release matching notes, then shift or rotate the cells; a clear empties the history.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         slot_rel[i]    = slot_ff[i];
         pressed_rel[i] = pressed_ff[i];
         if (do_note && pressed_ff[i] && (slot_ff[i].note == q_item.note)) begin
            pressed_rel[i]            = 1'b0;
            slot_rel[i].release_stamp = clock_ff;
         end
      end
      count_in = count_ff;
      if (do_onset) begin
         slot_in[0].note          = q_item.note;
         slot_in[0].velocity      = q_item.velocity;
         slot_in[0].press_stamp   = clock_ff;
         slot_in[0].release_stamp = '0;
         pressed_in[0]            = 1'b1;
         for (int i = 1; i < DEPTH; i++) begin
            slot_in[i]    = slot_rel[i-1];
            pressed_in[i] = pressed_rel[i-1];
         end
         count_in = (count_ff == DEPTH_CNT) ? count_ff : count_ff + 1'b1;
      end else if (do_rotate) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            slot_in[i]    = slot_ff[i+1];
            pressed_in[i] = pressed_ff[i+1];
         end
         slot_in[DEPTH-1]    = slot_ff[0];
         pressed_in[DEPTH-1] = pressed_ff[0];
      end else begin
         for (int i = 0; i < DEPTH; i++) begin
            slot_in[i]    = slot_rel[i];
            pressed_in[i] = pressed_rel[i];
         end
      end
      if (do_clear) begin
         pressed_in = '0;
         count_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         clock_ff     <= '0;
         idx_ff       <= '0;
         pressed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         clock_ff     <= clock_in;
         idx_ff       <= idx_in;
         pressed_ff   <= pressed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         slot_ff[i] <= slot_in[i];
      end
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   a_read_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_READ) |-> (count_ff != '0))
      else $error("read sequence running on an empty history");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("entry count beyond depth");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_IDLE && q_valid && q_item.op == OP_CLEAR) |=>
      (count_ff == '0 && clock_ff == '0 && pressed_ff == '0))
      else $error("clear did not empty the history");

   a_onset: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_IDLE && q_valid && q_item.op == OP_NOTE_ON) |=>
      (pressed_ff[0] && slot_ff[0].note == $past(q_item.note) &&
       slot_ff[0].press_stamp == $past(clock_ff)))
      else $error("onset not placed at the head of the history");

   a_marker: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.entry_present) |-> rsp_data_ff.last_entry)
      else $error("empty marker without last flag");
`endif

endmodule

FILE: rtl/core/midi_note_history_tracker.sv
// A read's first result passes through the queue register, the dispatch state and the read
// sequencer into the result register (an empty history's marker is loaded at dispatch). Note,
// tick, clear and an empty read are handled at dispatch; any other read holds the history unit
// for a dispatch step and one rotation step per slot, plus result stalls.
// A two-entry queue lets requests transfer while a read drains.
// Reset (synchronous, active high) empties history, queue and result register, zeroes the clock.
module midi_note_history_tracker import mnht_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   logic        q_valid;
   op_item_type q_item;
   logic        q_pop;

   mnht_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_pop)
   );

   mnht_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: tb/sv/tb_midi_note_history_tracker.sv
// Self-checking testbench for the MIDI note history tracker: queued stimulus, checked reads.
module tb_midi_note_history_tracker;
   import mnht_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int HIST_DEPTH     = DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS   = 250;
   localparam int CALM_TAIL      = 40;
   localparam int HOLD_AT_ITEM   = 80;
   localparam int HOLD_CYCLES    = 200;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 20;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   logic    req_full;
   req_type req_data = '0;
   logic    rsp_empty;
   logic    rsp_pop = 1'b0;
   rsp_type rsp_data;

   midi_note_history_tracker #(.DEPTH(HIST_DEPTH)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // history mirror
   logic [6:0]  hist_note     [HIST_DEPTH];
   logic [6:0]  hist_velocity [HIST_DEPTH];
   logic        hist_pressed  [HIST_DEPTH];
   logic [31:0] hist_press    [HIST_DEPTH];
   logic [31:0] hist_release  [HIST_DEPTH];
   int          hist_count = 0;
   logic [31:0] now_ms = '0;

   req_type req_backlog [$];
   rsp_type entry_reports_due [$];

   int mismatch_count = 0;
   int sent_count = 0;
   int seen_count = 0;
   int gap_left = 0;
   int stall_left = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   int quiet_cycles = 0;

   task automatic flag_mismatch(string what);
      mismatch_count++;
      $display("mismatch at result %0d: %s", seen_count, what);
   endtask

   task automatic wipe_history();
      hist_count = 0;
      now_ms = '0;
      for (int i = 0; i < HIST_DEPTH; i++) begin
         hist_note[i] = '0;
         hist_velocity[i] = '0;
         hist_pressed[i] = 1'b0;
         hist_press[i] = '0;
         hist_release[i] = '0;
      end
   endtask

   task automatic track_request(req_type r);
      rsp_type e;
      int      n;
      case (r.command)
         CMD_NOTE: begin
            for (int i = 0; i < hist_count; i++) begin
               if (hist_pressed[i] && hist_note[i] == r.note_number) begin
                  hist_pressed[i] = 1'b0;
                  hist_release[i] = now_ms;
               end
            end
            if (r.is_onset) begin
               n = (hist_count < HIST_DEPTH) ? hist_count + 1 : HIST_DEPTH;
               for (int i = n - 1; i >= 1; i--) begin
                  hist_note[i] = hist_note[i-1];
                  hist_velocity[i] = hist_velocity[i-1];
                  hist_pressed[i] = hist_pressed[i-1];
                  hist_press[i] = hist_press[i-1];
                  hist_release[i] = hist_release[i-1];
               end
               hist_note[0] = r.note_number;
               hist_velocity[0] = r.note_velocity;
               hist_pressed[0] = 1'b1;
               hist_press[0] = now_ms;
               hist_release[0] = '0;
               hist_count = n;
            end
         end
         CMD_TICK: now_ms = now_ms + 32'd1;
         CMD_READ: begin
            if (hist_count == 0) begin
               e = '0;
               e.last_entry = 1'b1;
               entry_reports_due.push_back(e);
            end
            for (int i = 0; i < hist_count; i++) begin
               e.entry_present = 1'b1;
               e.entry_note = hist_note[i];
               e.entry_velocity = hist_velocity[i];
               e.still_pressed = hist_pressed[i];
               e.ms_since_pressed = now_ms - hist_press[i];
               if (hist_pressed[i]) begin
                  e.ms_since_released = RELEASED_NONE;
                  e.held_ms = now_ms - hist_press[i];
               end else begin
                  e.ms_since_released = now_ms - hist_release[i];
                  e.held_ms = hist_release[i] - hist_press[i];
               end
               e.last_entry = (i == hist_count - 1);
               entry_reports_due.push_back(e);
            end
         end
         default: wipe_history();
      endcase
   endtask

   task automatic queue_item(logic [1:0] cmd, logic [6:0] note, logic [6:0] vel, logic onset);
      req_type r;
      r.command = cmd;
      r.note_number = note;
      r.note_velocity = vel;
      r.is_onset = onset;
      req_backlog.push_back(r);
   endtask

   function automatic req_type random_request(logic [6:0] base);
      req_type    r;
      logic [16:0] bits;
      int         pick;
      bits = 17'($urandom);
      r = bits;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         r.command = CMD_NOTE;
         r.is_onset = ($urandom_range(0, 9) < 7);
         if ($urandom_range(0, 3) != 0) r.note_number = base + 7'($urandom_range(0, 7));
      end else if (pick < 80) begin
         r.command = CMD_TICK;
      end else if (pick < 99) begin
         r.command = CMD_READ;
      end else begin
         r.command = CMD_CLEAR;
      end
      return r;
   endfunction

   function automatic bit idling_allowed();
      return req_backlog.size() >= CALM_TAIL && ((sent_count / 32) % 3) != 1;
   endfunction

   // driver
   always @(posedge clock) begin
      bit advance;
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         advance = 1'b1;
         if (req_push && !req_full) begin
            track_request(req_data);
            sent_count++;
         end else if (req_push) begin
            advance = 1'b0;
         end
         if (advance) begin
            if (gap_left > 0) begin
               gap_left--;
               req_push <= 1'b0;
            end else if (req_backlog.size() == 0) begin
               req_push <= 1'b0;
            end else if (idling_allowed() && hold_left == 0 && $urandom_range(0, 5) == 0) begin
               gap_left = $urandom_range(1, 12) - 1;
               req_push <= 1'b0;
            end else begin
               req_push <= 1'b1;
               req_data <= req_backlog.pop_front();
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (entry_reports_due.size() == 0) begin
               flag_mismatch("result with nothing expected");
            end else begin
               want = entry_reports_due.pop_front();
               if (rsp_data.entry_present !== want.entry_present)
                  flag_mismatch($sformatf("entry_present %0h want %0h",
                     rsp_data.entry_present, want.entry_present));
               if (rsp_data.entry_note !== want.entry_note)
                  flag_mismatch($sformatf("entry_note %0h want %0h",
                     rsp_data.entry_note, want.entry_note));
               if (rsp_data.entry_velocity !== want.entry_velocity)
                  flag_mismatch($sformatf("entry_velocity %0h want %0h",
                     rsp_data.entry_velocity, want.entry_velocity));
               if (rsp_data.still_pressed !== want.still_pressed)
                  flag_mismatch($sformatf("still_pressed %0h want %0h",
                     rsp_data.still_pressed, want.still_pressed));
               if (rsp_data.ms_since_pressed !== want.ms_since_pressed)
                  flag_mismatch($sformatf("ms_since_pressed %0h want %0h",
                     rsp_data.ms_since_pressed, want.ms_since_pressed));
               if (rsp_data.ms_since_released !== want.ms_since_released)
                  flag_mismatch($sformatf("ms_since_released %0h want %0h",
                     rsp_data.ms_since_released, want.ms_since_released));
               if (rsp_data.held_ms !== want.held_ms)
                  flag_mismatch($sformatf("held_ms %0h want %0h",
                     rsp_data.held_ms, want.held_ms));
               if (rsp_data.last_entry !== want.last_entry)
                  flag_mismatch($sformatf("last_entry %0h want %0h",
                     rsp_data.last_entry, want.last_entry));
            end
            seen_count++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (!hold_done && sent_count >= HOLD_AT_ITEM) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_pop <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_pop <= 1'b0;
         end else if (idling_allowed() && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 12) - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("FAIL midi_note_history_tracker");
            $finish;
         end
      end
   end

   initial begin
      logic [6:0] base;
      wipe_history();

      queue_item(CMD_READ, 7'd0, 7'd0, 1'b0);
      queue_item(CMD_NOTE, 7'd0, 7'd0, 1'b1);
      queue_item(CMD_NOTE, 7'd127, 7'd127, 1'b1);
      queue_item(CMD_TICK, 7'd127, 7'd127, 1'b1);
      queue_item(CMD_NOTE, 7'd64, 7'd1, 1'b1);
      queue_item(CMD_TICK, 7'd0, 7'd0, 1'b0);
      queue_item(CMD_TICK, 7'd85, 7'd42, 1'b0);
      queue_item(CMD_NOTE, 7'd0, 7'd99, 1'b0);
      queue_item(CMD_NOTE, 7'd5, 7'd10, 1'b0);
      queue_item(CMD_READ, 7'd127, 7'd127, 1'b1);
      queue_item(CMD_NOTE, 7'd127, 7'd100, 1'b1);
      queue_item(CMD_TICK, 7'd0, 7'd0, 1'b0);
      queue_item(CMD_READ, 7'd0, 7'd0, 1'b0);
      queue_item(CMD_NOTE, 7'd127, 7'd0, 1'b0);
      queue_item(CMD_TICK, 7'd0, 7'd0, 1'b0);
      queue_item(CMD_READ, 7'd42, 7'd85, 1'b1);
      queue_item(CMD_CLEAR, 7'd127, 7'd127, 1'b1);
      queue_item(CMD_READ, 7'd0, 7'd0, 1'b0);
      queue_item(CMD_NOTE, 7'd127, 7'd127, 1'b0);
      queue_item(CMD_READ, 7'd0, 7'd0, 1'b0);

      base = 7'($urandom);
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k % 40 == 0) base = 7'($urandom);
         req_backlog.push_back(random_request(base));
      end
      queue_item(CMD_READ, 7'd0, 7'd0, 1'b0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (req_backlog.size() != 0 || req_push || entry_reports_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && entry_reports_due.size() == 0) begin
         $display("PASS midi_note_history_tracker");
      end else begin
         $display("FAIL midi_note_history_tracker");
      end
      $finish;
   end

endmodule
